// File: hdl/idvi_pkg.sv
// ----------------------------------------------------------------------------
// idvi_pkg
// Shared types and constants of the inverse distance vector interpolator.
// ----------------------------------------------------------------------------
package idvi_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int POS_W       = 16;
  localparam int DIR_W       = 16;
  localparam int THR_W       = 16;
  localparam int CFG_W       = 16;
  localparam int D2_W        = 35;
  localparam int WT_W        = 49;
  localparam int SUMW_W      = WT_W + IDX_W;
  localparam int PROD_W      = 64;
  localparam int ACC_W       = PROD_W + IDX_W + 1;
  localparam int NUM_W       = ACC_W + 1;
  localparam int REM_W       = SUMW_W + 1;
  localparam int FQ_W        = 17;
  localparam int WDIV_STEPS  = WT_W;
  localparam int FDIV_STEPS  = FQ_W;
  localparam int STEP_W      = 6;
  localparam int ENTRY_W     = 3 * POS_W + 3 * DIR_W;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_HIT    = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_STORED = 2'd3;

  localparam logic REG_POINT_COUNT   = 1'b0;
  localparam logic REG_HIT_THRESHOLD = 1'b1;

  localparam logic MODE_STORE = 1'b0;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_z;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_x;
    logic [POS_W-1:0]        pos_z;
    logic [POS_W-1:0]        pos_y;
    logic [POS_W-1:0]        pos_x;
    logic [IDX_W-1:0]        point_index;
  } req_t;

  typedef struct packed {
    logic             store;
    logic             start;
    logic             ram_rd;
    logic [IDX_W-1:0] addr;
    logic             ld_d2;
    logic             div_ld_w;
    logic             div_ld_f;
    logic             div_step;
    logic             ld_prod;
    logic             acc_add;
    logic             ld_res;
    logic [1:0]       comp;
    logic             out_ld;
    logic [1:0]       out_status;
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic             empty;
    logic [CNT_W-1:0] n_eff;
  } stat_t;

endpackage

// File: hdl/idvi_ram.sv
// ----------------------------------------------------------------------------
// idvi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module idvi_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/idvi_dp.sv
// ----------------------------------------------------------------------------
// idvi_dp
// Datapath: point table, distance, shared restoring divider, accumulators.
// ----------------------------------------------------------------------------
module idvi_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  idvi_pkg::cmd_t                   cmd,
  input  idvi_pkg::req_t                   req,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [idvi_pkg::CFG_W-1:0]       cfg_data,
  output idvi_pkg::stat_t                  stat,
  output logic signed [idvi_pkg::DIR_W-1:0] spin_x,
  output logic signed [idvi_pkg::DIR_W-1:0] spin_y,
  output logic signed [idvi_pkg::DIR_W-1:0] spin_z,
  output logic [1:0]                       status
);
  import idvi_pkg::*;

  logic [CNT_W-1:0]        point_count;
  logic [THR_W-1:0]        hit_threshold;
  logic [POS_W-1:0]        qpos [3];
  logic signed [DIR_W-1:0] pdir [3];
  logic [ENTRY_W-1:0]      rdata;
  logic [D2_W-1:0]         d2;
  logic [PROD_W-1:0]       prod [3];
  logic                    pneg [3];
  logic signed [ACC_W-1:0] acc [3];
  logic [SUMW_W-1:0]       sumw;
  logic [REM_W-1:0]        rem;
  logic [NUM_W-1:0]        num;
  logic [WT_W-1:0]         quo;
  logic signed [DIR_W-1:0] res [3];

  logic [REM_W-1:0]        divisor;
  logic [REM_W-1:0]        rem_sh;
  logic                    ge;
  logic [D2_W-1:0]         d2_c;
  logic [POS_W-1:0]        ppos [3];
  logic signed [POS_W:0]   dq [3];
  logic signed [2*POS_W+1:0] sq [3];
  logic signed [ACC_W-1:0] fa;
  logic [ACC_W-1:0]        fmag;
  logic [NUM_W-1:0]        fnum;
  logic [FQ_W:0]           qsum;
  logic [FQ_W-1:0]         qr;
  logic signed [DIR_W-1:0] rnd;
  logic                    state_is_w;
  logic                    div_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= '0;
      hit_threshold <= THR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT_COUNT:   point_count   <= cfg_data[CNT_W-1:0];
        REG_HIT_THRESHOLD: hit_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.n_eff = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;
  assign stat.empty = (point_count == '0);
  assign stat.hit   = (d2 == '0) || (d2 < D2_W'(hit_threshold));

  idvi_ram #(.W(ENTRY_W), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (req.point_index),
    .wdata ({req.dir_z, req.dir_y, req.dir_x, req.pos_z, req.pos_y, req.pos_x}),
    .re    (cmd.ram_rd),
    .raddr (cmd.addr),
    .rdata (rdata)
  );

  always_comb begin
    d2_c = '0;
    for (int c = 0; c < 3; c++) begin
      ppos[c] = rdata[c*POS_W +: POS_W];
      dq[c]   = $signed({1'b0, qpos[c]}) - $signed({1'b0, ppos[c]});
      sq[c]   = dq[c] * dq[c];
      d2_c    = d2_c + D2_W'($unsigned(sq[c]));
    end
  end

  assign divisor = cmd.div_ld_w ? REM_W'(d2) : (state_is_w ? REM_W'(d2) : REM_W'(sumw));
  always_ff @(posedge clk) begin
    if (cmd.div_ld_w) begin
      div_w <= 1'b1;
    end else if (cmd.div_ld_f) begin
      div_w <= 1'b0;
    end
  end
  assign state_is_w = div_w;

  assign rem_sh = {rem[REM_W-2:0], num[NUM_W-1]};
  assign ge     = (rem_sh >= divisor);

  assign fa   = acc[cmd.comp];
  assign fmag = fa[ACC_W-1] ? ACC_W'(-fa) : ACC_W'(fa);
  assign fnum = {fmag, 1'b0};
  assign qsum = {1'b0, quo[FQ_W-1:0]} + (FQ_W+1)'(1);
  assign qr   = qsum[FQ_W:1];

  always_comb begin
    if (fa[ACC_W-1]) begin
      rnd = (qr >= FQ_W'(32768)) ? -16'sd32768 : -$signed(qr[DIR_W-1:0]);
    end else begin
      rnd = (qr > FQ_W'(32767)) ? 16'sd32767 : $signed(qr[DIR_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qpos[0] <= req.pos_x;
      qpos[1] <= req.pos_y;
      qpos[2] <= req.pos_z;
      sumw    <= '0;
      for (int c = 0; c < 3; c++) begin
        acc[c] <= '0;
      end
    end
    if (cmd.ld_d2) begin
      d2 <= d2_c;
      for (int c = 0; c < 3; c++) begin
        pdir[c] <= $signed(rdata[3*POS_W + c*DIR_W +: DIR_W]);
      end
    end
    if (cmd.div_ld_w) begin
      rem <= '0;
      num <= {1'b1, (NUM_W-1)'(0)};
      quo <= '0;
    end else if (cmd.div_ld_f) begin
      rem <= {1'b0, fnum[NUM_W-1:FQ_W]};
      num <= {fnum[FQ_W-1:0], (NUM_W-FQ_W)'(0)};
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? (rem_sh - divisor) : rem_sh;
      num <= {num[NUM_W-2:0], 1'b0};
      quo <= {quo[WT_W-2:0], ge};
    end
    if (cmd.ld_prod) begin
      for (int c = 0; c < 3; c++) begin
        pneg[c] <= pdir[c][DIR_W-1];
        prod[c] <= PROD_W'(quo * (pdir[c][DIR_W-1] ? DIR_W'(-pdir[c]) : DIR_W'(pdir[c])));
      end
    end
    if (cmd.acc_add) begin
      sumw <= sumw + SUMW_W'(quo);
      for (int c = 0; c < 3; c++) begin
        acc[c] <= pneg[c] ? acc[c] - $signed(ACC_W'(prod[c]))
                          : acc[c] + $signed(ACC_W'(prod[c]));
      end
    end
    if (cmd.ld_res) begin
      res[cmd.comp] <= rnd;
    end
    if (cmd.out_ld) begin
      status <= cmd.out_status;
      case (cmd.out_status)
        ST_HIT: begin
          spin_x <= pdir[0];
          spin_y <= pdir[1];
          spin_z <= pdir[2];
        end
        ST_INTERP: begin
          spin_x <= res[0];
          spin_y <= res[1];
          spin_z <= res[2];
        end
        default: begin
          spin_x <= '0;
          spin_y <= '0;
          spin_z <= '0;
        end
      endcase
    end
  end

endmodule

// File: hdl/idvi_ctrl.sv
// ----------------------------------------------------------------------------
// idvi_ctrl
// Controller: request handshake, point walk, divider sequencing, result hold.
// ----------------------------------------------------------------------------
module idvi_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  output logic            s_ready,
  input  logic            mode,
  output logic            m_valid,
  input  logic            m_ready,
  input  idvi_pkg::stat_t stat,
  output idvi_pkg::cmd_t  cmd
);
  import idvi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_D2   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_WDIV = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_FSET = 4'd7;
  localparam logic [3:0] S_FDIV = 4'd8;
  localparam logic [3:0] S_FRES = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] pidx, pidx_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic [1:0]       comp, comp_next;
  logic             hit, hit_next;
  logic             out_free;
  logic             accept;

  assign out_free = !m_valid || m_ready;
  assign s_ready  = (state == S_IDLE) && out_free;
  assign accept   = s_valid && s_ready;

  always_comb begin
    state_next = state;
    pidx_next  = pidx;
    cnt_next   = cnt;
    comp_next  = comp;
    hit_next   = hit;
    cmd        = '0;
    cmd.addr   = pidx[IDX_W-1:0];
    cmd.comp   = comp;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_STORE) begin
            cmd.store      = 1'b1;
            cmd.out_ld     = 1'b1;
            cmd.out_status = ST_STORED;
          end else if (stat.empty) begin
            cmd.out_ld     = 1'b1;
            cmd.out_status = ST_EMPTY;
          end else begin
            cmd.start  = 1'b1;
            pidx_next  = '0;
            hit_next   = 1'b0;
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.ram_rd = 1'b1;
        state_next = S_D2;
      end
      S_D2: begin
        cmd.ld_d2  = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.hit) begin
          hit_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.div_ld_w = 1'b1;
          cnt_next     = '0;
          state_next   = S_WDIV;
        end
      end
      S_WDIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + STEP_W'(1);
        if (cnt == STEP_W'(WDIV_STEPS - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.ld_prod = 1'b1;
        state_next  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        pidx_next   = pidx + CNT_W'(1);
        if (pidx + CNT_W'(1) == stat.n_eff) begin
          comp_next  = '0;
          state_next = S_FSET;
        end else begin
          state_next = S_RD;
        end
      end
      S_FSET: begin
        cmd.div_ld_f = 1'b1;
        cnt_next     = '0;
        state_next   = S_FDIV;
      end
      S_FDIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + STEP_W'(1);
        if (cnt == STEP_W'(FDIV_STEPS - 1)) begin
          state_next = S_FRES;
        end
      end
      S_FRES: begin
        cmd.ld_res = 1'b1;
        if (comp == 2'd2) begin
          state_next = S_DONE;
        end else begin
          comp_next  = comp + 2'd1;
          state_next = S_FSET;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = hit ? ST_HIT : ST_INTERP;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pidx    <= '0;
      cnt     <= '0;
      comp    <= '0;
      hit     <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      pidx  <= pidx_next;
      cnt   <= cnt_next;
      comp  <= comp_next;
      hit   <= hit_next;
      if (cmd.out_ld) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_ready |-> state == S_IDLE)
    else $error("request taken outside idle");
  a_pidx_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> pidx < stat.n_eff)
    else $error("point walk past table end");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WDIV |-> cnt < STEP_W'(WDIV_STEPS))
    else $error("weight divide overran");
  a_comp_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FSET |-> comp <= 2'd2)
    else $error("component index out of range");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> $past(1'b1) && out_free)
    else $error("result overwritten before taken");
`endif

endmodule

// File: hdl/inverse_distance_vector_interp.sv
// ----------------------------------------------------------------------------
// inverse_distance_vector_interp
// Shepard inverse distance (power 2) interpolation of a direction field.
// ----------------------------------------------------------------------------
// Requests enter on the s_ side: s_tuser is the mode (0 store, 1 query).
// A store writes one table entry and returns status 3.
// A query walks the first point_count entries (capped at 64); each entry
// takes a table read and distance, then the one-bit-per-cycle weight divider
// (49 steps), a multiply and an accumulate. A hit (squared distance zero or
// below hit_threshold) ends the walk at once. Otherwise three final divides,
// one per direction component, follow.
// One request is in flight at a time; results sit in an output register on
// the m_ side and a new request is taken while the old result is being
// taken. If m_tready stays low, the block holds its result and waits.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken in any
// cycle and are meant for idle periods. Reset clears control state and sets
// point_count to 0 and hit_threshold to 1; table contents stay undefined.
// ----------------------------------------------------------------------------
module inverse_distance_vector_interp (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // point_index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
  input  logic [0:0]   s_tuser,  // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,  // spin_x, spin_y, spin_z
  output logic [1:0]   m_tuser,  // status
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  import idvi_pkg::*;

  req_t                    req;
  cmd_t                    cmd;
  stat_t                   stat;
  logic signed [DIR_W-1:0] spin_x, spin_y, spin_z;

  assign req     = s_tdata[$bits(req_t)-1:0];
  assign m_tdata = {spin_z, spin_y, spin_x};

  idvi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .mode    (s_tuser[0]),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  idvi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .spin_x    (spin_x),
    .spin_y    (spin_y),
    .spin_z    (spin_z),
    .status    (m_tuser)
  );

endmodule

// File: verif/idvi_checker.sv
// ----------------------------------------------------------------------------
// idvi_checker
// Watches the request, result and register ports of the interpolator, keeps
// its own copy of the point table and registers, computes the expected
// direction and status of every request and compares results in order.
// ----------------------------------------------------------------------------
module idvi_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,  // point_index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
  input  logic [0:0]   s_tuser,  // mode
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [47:0]  m_tdata,  // spin_x, spin_y, spin_z
  input  logic [1:0]   m_tuser,  // status
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import idvi_pkg::*;

  typedef struct packed {
    logic signed [15:0] spin_z;
    logic signed [15:0] spin_y;
    logic signed [15:0] spin_x;
    logic [1:0]         status;
  } spin_t;

  logic [15:0]        tbl_pos [MAX_POINTS][3];
  logic signed [15:0] tbl_dir [MAX_POINTS][3];
  logic [6:0]         num_points;
  logic [15:0]        hit_thr;
  spin_t              spin_q[$];

  function automatic logic signed [15:0] round_mean(logic signed [127:0] acc,
                                                    logic [127:0] sumw);
    logic         neg;
    logic [127:0] mag;
    logic [127:0] q;
    neg = acc[127];
    mag = neg ? -acc : acc;
    q = (mag << 1) / sumw;
    q = (q + 1) >> 1;
    if (neg) return (q >= 32768) ? -16'sd32768 : -$signed(q[15:0]);
    return (q > 32767) ? 16'sd32767 : $signed(q[15:0]);
  endfunction

  function automatic spin_t interp_spin(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    spin_t              r;
    int                 n;
    longint             dx, dy, dz, prod;
    longint unsigned    d2, w;
    logic [127:0]       sumw;
    logic signed [127:0] acc [3];
    r = '0;
    n = (num_points > MAX_POINTS) ? MAX_POINTS : num_points;
    if (n == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    sumw = '0;
    for (int c = 0; c < 3; c++) acc[c] = '0;
    for (int i = 0; i < n; i++) begin
      dx = longint'(px) - longint'(tbl_pos[i][0]);
      dy = longint'(py) - longint'(tbl_pos[i][1]);
      dz = longint'(pz) - longint'(tbl_pos[i][2]);
      d2 = dx * dx + dy * dy + dz * dz;
      if (d2 == 0 || d2 < hit_thr) begin
        r.spin_x = tbl_dir[i][0];
        r.spin_y = tbl_dir[i][1];
        r.spin_z = tbl_dir[i][2];
        r.status = ST_HIT;
        return r;
      end
      w = (64'd1 << 48) / d2;
      sumw += w;
      for (int c = 0; c < 3; c++) begin
        prod = longint'(w) * longint'(tbl_dir[i][c]);
        acc[c] = acc[c] + {{64{prod[63]}}, prod};
      end
    end
    r.spin_x = round_mean(acc[0], sumw);
    r.spin_y = round_mean(acc[1], sumw);
    r.spin_z = round_mean(acc[2], sumw);
    r.status = ST_INTERP;
    return r;
  endfunction

  always @(posedge clk) begin
    req_t  rq;
    spin_t e, got;
    if (rst) begin
      num_points <= '0;
      hit_thr    <= 16'd1;
      errors     <= 0;
      spin_q.delete();
      pending    <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_POINT_COUNT) num_points <= cfg_data[6:0];
        else hit_thr <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        rq = req_t'(s_tdata[101:0]);
        if (s_tuser[0] == MODE_STORE) begin
          tbl_pos[rq.point_index][0] = rq.pos_x;
          tbl_pos[rq.point_index][1] = rq.pos_y;
          tbl_pos[rq.point_index][2] = rq.pos_z;
          tbl_dir[rq.point_index][0] = rq.dir_x;
          tbl_dir[rq.point_index][1] = rq.dir_y;
          tbl_dir[rq.point_index][2] = rq.dir_z;
          e = '0;
          e.status = ST_STORED;
        end else begin
          e = interp_spin(rq.pos_x, rq.pos_y, rq.pos_z);
        end
        spin_q.push_back(e);
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tuser};
        if (spin_q.size() == 0) begin
          $display("%t unexpected result: actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          e = spin_q.pop_front();
          if (got.spin_x !== e.spin_x || got.spin_y !== e.spin_y ||
              got.spin_z !== e.spin_z || got.status !== e.status) begin
            $display("%t result wrong: expected x=%0d y=%0d z=%0d st=%0d, %s",
                     $time, e.spin_x, e.spin_y, e.spin_z, e.status, "actual");
            $display("%t   actual x=%0d y=%0d z=%0d st=%0d",
                     $time, got.spin_x, got.spin_y, got.spin_z, got.status);
            errors <= errors + 1;
          end
        end
      end
      pending <= spin_q.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives table stores, queries and register settings into the interpolator
// with random gaps and result stalls; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import idvi_pkg::*;

  localparam logic MODE_QUERY = ~MODE_STORE;
  localparam int   CYCLE_LIMIT = 20000000;
  localparam int   NUM_REQS = 1050;

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [103:0] s_tdata;  // point_index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
  logic [0:0]   s_tuser;  // mode
  logic         m_tvalid, m_tready;
  logic [47:0]  m_tdata;  // spin_x, spin_y, spin_z
  logic [1:0]   m_tuser;  // status
  logic         cfg_we;
  logic         cfg_index;
  logic [15:0]  cfg_data;
  int           errors, pending;
  int           cycles = 0;
  int           n_sent, n_stores, n_queries, n_settings, n_eff;
  bit           calm;
  logic [15:0]  tbl_pos [MAX_POINTS][3];

  inverse_distance_vector_interp dut (.*);

  idvi_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("inverse_distance_vector_interp: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // hold off a random number of cycles, then present one request
  task automatic send_req(logic mode, logic [5:0] idx, logic [15:0] px, logic [15:0] py,
                          logic [15:0] pz, logic [15:0] dx, logic [15:0] dy,
                          logic [15:0] dz);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b00, dz, dy, dx, pz, py, px, idx};
    if (mode == MODE_STORE) begin
      tbl_pos[idx][0] = px;
      tbl_pos[idx][1] = py;
      tbl_pos[idx][2] = pz;
      n_stores++;
    end else begin
      n_queries++;
    end
    n_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic store_rand(logic [5:0] idx);
    send_req(MODE_STORE, idx, pick16(), pick16(), pick16(), pick16(), pick16(), pick16());
  endtask

  task automatic query_rand();
    int          k, kind;
    logic [15:0] p [3];
    kind = $urandom_range(0, 9);
    k = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
    for (int c = 0; c < 3; c++) begin
      if (n_eff > 0 && kind < 2) p[c] = tbl_pos[k][c];
      else if (n_eff > 0 && kind < 6) p[c] = tbl_pos[k][c] + 16'($signed($urandom_range(0, 6)) - 3);
      else p[c] = pick16();
    end
    send_req(MODE_QUERY, 6'($urandom), p[0], p[1], p[2],
             16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(int cnt, int thr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_POINT_COUNT;
    cfg_data  <= 16'(cnt);
    @(posedge clk);
    cfg_index <= REG_HIT_THRESHOLD;
    cfg_data  <= 16'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_eff = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
    n_settings++;
  endtask

  // result side: stall a random number of cycles after each result
  initial begin
    int st;
    st = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tready && m_tvalid) begin
        st = calm ? 0 : $urandom_range(0, 8);
        if (st > 0) m_tready <= 1'b0;
      end else if (!m_tready) begin
        if (st > 0) st--;
        if (st == 0) m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int cnt, thr, len;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = REG_POINT_COUNT;
    cfg_data = '0;
    n_sent = 0;
    n_stores = 0;
    n_queries = 0;
    n_settings = 0;
    n_eff = 0;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, then stores with extreme content
    send_req(MODE_QUERY, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0);
    send_req(MODE_QUERY, 6'd63, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_req(MODE_STORE, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h0000);
    send_req(MODE_STORE, 6'd1, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h7fff, 16'hffff);
    send_req(MODE_STORE, 6'd2, 16'hffff, 16'h0000, 16'h8000, 16'h0001, 16'hffff, 16'h3039);
    for (int i = 3; i < 8; i++) store_rand(6'(i));
    store_rand(6'd63);
    drain();

    set_regs(8, 0);
    send_req(MODE_QUERY, 6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0);
    send_req(MODE_QUERY, 6'd0, 16'hffff, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0);
    send_req(MODE_QUERY, 6'd0, 16'h0001, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0);
    send_req(MODE_QUERY, 6'd0, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0);
    send_req(MODE_QUERY, 6'd0, 16'hffff, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0);
    drain();
    set_regs(8, 65535);
    send_req(MODE_QUERY, 6'd0, 16'h0000, 16'h0000, 16'h0064, 16'h0, 16'h0, 16'h0);
    drain();

    // fill the whole table so any count is safe from here on
    for (int i = 0; i < MAX_POINTS; i++) store_rand(6'(i));
    drain();

    while (n_sent < NUM_REQS) begin
      case ($urandom_range(0, 9))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = 64;
        3: cnt = 127;
        4: cnt = $urandom_range(65, 126);
        default: cnt = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 4))
        0: thr = 0;
        1: thr = 1;
        2: thr = 65535;
        3: thr = $urandom_range(0, 64);
        default: thr = $urandom_range(0, 65535);
      endcase
      set_regs(cnt, thr);
      calm = ($urandom_range(0, 3) == 0);
      len = (n_eff > 16) ? 12 : 90;
      for (int i = 0; i < len; i++) begin
        if (i == len / 2) drain();
        if ($urandom_range(0, 3) == 0) store_rand(6'($urandom));
        else query_rand();
      end
      drain();
    end

    $display("%0d requests: %0d table stores, %0d queries, %0d register settings",
             n_sent, n_stores, n_queries, n_settings);
    $display("queries covered empty table, exact hits, near points and far interpolation");
    if (errors == 0) begin
      $display("inverse_distance_vector_interp: match");
    end else begin
      $display("inverse_distance_vector_interp: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/idvi_pkg.sv
hdl/idvi_ram.sv
hdl/idvi_dp.sv
hdl/idvi_ctrl.sv
hdl/inverse_distance_vector_interp.sv
verif/idvi_checker.sv
verif/tb_top.sv
